/* rtl/core/qpse_pkg.sv */
// ----------------------------------------------------------------------------
// qpse_pkg
// Shared types and constants of the quadrature position and speed estimator.
// ----------------------------------------------------------------------------
package qpse_pkg;

    localparam int SPEED_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int POS_BITS   = 15;
    localparam int CNT_BITS   = 16;
    // dividend 1000000 * pulses, pulses up to 16 bits
    localparam int DIVD_BITS  = 36;
    localparam int QCNT_BITS  = 6;
    localparam logic [19:0] US_PER_SECOND = 20'd1000000;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

    localparam logic [1:0] CMD_CW_PIN  = 2'd0;
    localparam logic [1:0] CMD_CCW_PIN = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_HOME    = 2'd3;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CCW  = 2'd1;
    localparam logic [1:0] DIR_CW   = 2'd3;

    localparam logic [1:0] REG_PPR     = 2'd0;
    localparam logic [1:0] REG_THRESH  = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_PULSE,
        OP_TICK,
        OP_HOME
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [1:0]           dir;
        logic [TIME_BITS-1:0] now;
    } cmd_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FILTER,
        ST_MODE,
        ST_EMIT
    } back_state_t;

endpackage

/* rtl/core/quadrature_position_speed_estimator.sv */
// ----------------------------------------------------------------------------
// quadrature_position_speed_estimator
// Encoder position counter with pulse-timing and pulse-counting speed.
// ----------------------------------------------------------------------------
// One result per input transaction. The back end goes from idle straight to
// emit on a home command or a counting-mode edge, through filter on a
// timing-mode edge with zero gap, through mode on a tick without speed
// update, and through filter and mode on a tick that filters without dividing.
// A speed update that divides passes divide and filter, plus mode on a tick;
// the serial divider produces one of 36 quotient bits per clock. The two entry
// queue in front keeps the item at work, so one more can be accepted meanwhile.
module quadrature_position_speed_estimator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   cmd,
    input  logic         other_phase_level,
    input  logic [31:0]  now_us,
    output logic         empty,
    input  logic         pop,
    output logic [14:0]  position_out,
    output logic [15:0]  speed_out,
    output logic signed [16:0] velocity_out,
    output logic         fast_mode_out,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [14:0] ppr_reg;
    logic [15:0] thresh_reg;
    logic [15:0] period_reg;
    logic [31:0] timeout_reg;
    logic        item_valid;
    logic        item_take;
    qpse_pkg::cmd_item_t item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg     <= 15'd1024;
            thresh_reg  <= 16'd130;
            period_reg  <= 16'd16255;
            timeout_reg <= 32'd1000000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qpse_pkg::REG_PPR:    ppr_reg    <= cfg_data[14:0];
                qpse_pkg::REG_THRESH: thresh_reg <= cfg_data[15:0];
                qpse_pkg::REG_PERIOD: period_reg <= cfg_data[15:0];
                default:              timeout_reg <= cfg_data;
            endcase
        end
    end

    qpse_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .cmd               (cmd),
        .other_phase_level (other_phase_level),
        .now_us            (now_us),
        .item_valid        (item_valid),
        .item              (item),
        .item_take         (item_take)
    );

    qpse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .ppr           (ppr_reg),
        .thresh        (thresh_reg),
        .period        (period_reg),
        .timeout       (timeout_reg),
        .empty         (empty),
        .pop           (pop),
        .position_out  (position_out),
        .speed_out     (speed_out),
        .velocity_out  (velocity_out),
        .fast_mode_out (fast_mode_out)
    );

endmodule

/* rtl/core/qpse_front.sv */
// ----------------------------------------------------------------------------
// qpse_front
// Accepts input transactions, decodes direction, and queues them (2 deep).
// ----------------------------------------------------------------------------
module qpse_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 cmd,
    input  logic                       other_phase_level,
    input  logic [31:0]                now_us,
    output logic                       item_valid,
    output qpse_pkg::cmd_item_t        item,
    input  logic                       item_take
);

    qpse_pkg::cmd_item_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    qpse_pkg::cmd_item_t dec;
    logic do_push;
    logic do_pop;

    // direction decode and classification
    always_comb
    begin
        dec.now = now_us[qpse_pkg::TIME_BITS-1:0];
        dec.dir = qpse_pkg::DIR_NONE;
        case (cmd)
            qpse_pkg::CMD_CW_PIN:
            begin
                dec.op  = qpse_pkg::OP_PULSE;
                dec.dir = other_phase_level ? qpse_pkg::DIR_CCW : qpse_pkg::DIR_CW;
            end
            qpse_pkg::CMD_CCW_PIN:
            begin
                dec.op  = qpse_pkg::OP_PULSE;
                dec.dir = other_phase_level ? qpse_pkg::DIR_CW : qpse_pkg::DIR_CCW;
            end
            qpse_pkg::CMD_TICK: dec.op = qpse_pkg::OP_TICK;
            default:            dec.op = qpse_pkg::OP_HOME;
        endcase
    end

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= dec;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("front queue count out of range");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !do_pop) |=> full) else $error("full dropped without a pop");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");

endmodule

/* rtl/core/qpse_divider.sv */
// ----------------------------------------------------------------------------
// qpse_divider
// Restoring serial divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module qpse_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [qpse_pkg::DIVD_BITS-1:0]    dividend,
    input  logic [qpse_pkg::TIME_BITS-1:0]    divisor,
    output logic                              done,
    output logic [qpse_pkg::SPEED_BITS-1:0]   quotient
);

    localparam int RB = qpse_pkg::TIME_BITS + 1;

    logic [qpse_pkg::DIVD_BITS-1:0] q_reg;
    logic [RB-1:0]                  r_reg;
    logic [qpse_pkg::TIME_BITS-1:0] d_reg;
    logic [qpse_pkg::QCNT_BITS-1:0] n_reg;
    logic                           busy_reg;
    logic [RB-1:0]                  shifted;
    logic [RB-1:0]                  diff;

    assign shifted = {r_reg[RB-2:0], q_reg[qpse_pkg::DIVD_BITS-1]};
    assign diff    = shifted - {1'b0, d_reg};

    // one quotient bit per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                n_reg    <= qpse_pkg::QCNT_BITS'(qpse_pkg::DIVD_BITS);
            end
            else if (busy_reg)
            begin
                n_reg <= n_reg - 1'b1;
                if (n_reg == qpse_pkg::QCNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[RB-1])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[qpse_pkg::DIVD_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[qpse_pkg::DIVD_BITS-2:0], 1'b0};
            end
        end
    end

    assign quotient = (q_reg[qpse_pkg::DIVD_BITS-1:qpse_pkg::SPEED_BITS] != '0)
                      ? qpse_pkg::SPEED_MAX : q_reg[qpse_pkg::SPEED_BITS-1:0];

endmodule

/* rtl/core/qpse_back.sv */
// ----------------------------------------------------------------------------
// qpse_back
// Executes queued operations: position, speed measurement, filter, output.
// ----------------------------------------------------------------------------
module qpse_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  qpse_pkg::cmd_item_t               item,
    output logic                              item_take,
    input  logic [qpse_pkg::POS_BITS-1:0]     ppr,
    input  logic [qpse_pkg::SPEED_BITS-1:0]   thresh,
    input  logic [15:0]                       period,
    input  logic [31:0]                       timeout,
    output logic                              empty,
    input  logic                              pop,
    output logic [qpse_pkg::POS_BITS-1:0]     position_out,
    output logic [qpse_pkg::SPEED_BITS-1:0]   speed_out,
    output logic signed [qpse_pkg::SPEED_BITS:0] velocity_out,
    output logic                              fast_mode_out
);

    localparam int SB = qpse_pkg::SPEED_BITS;
    localparam int TB = qpse_pkg::TIME_BITS;

    qpse_pkg::back_state_t state_reg, state_next;
    logic [qpse_pkg::POS_BITS-1:0] pos_reg;
    logic [1:0]                    dir_reg;
    logic [SB-1:0]                 speed_reg;
    logic [qpse_pkg::CNT_BITS-1:0] cnt_reg;
    logic [TB-1:0]                 last_reg;
    logic                          fast_reg;
    logic                          out_full_reg;
    logic [SB-1:0]                 raw_reg;
    logic                          tick_reg;

    logic [TB-1:0]                 gap;
    logic [qpse_pkg::POS_BITS-1:0] pos_next;
    logic                          div_start;
    logic [qpse_pkg::DIVD_BITS-1:0] div_num;
    logic [TB-1:0]                 div_den;
    logic                          div_done;
    logic [SB-1:0]                 div_q;
    logic [SB+2:0]                 filt;
    logic                          out_free;

    assign gap      = item.now - last_reg;
    assign out_free = !out_full_reg || pop;
    assign empty    = !out_full_reg;
    assign filt     = ({3'b0, raw_reg} << 2) + {3'b0, raw_reg}
                      + ({3'b0, speed_reg} << 1) + {3'b0, speed_reg};

    // position wrap
    always_comb
    begin
        if (item.dir == qpse_pkg::DIR_CCW)
        begin
            pos_next = (({1'b0, pos_reg} + 1'b1) >= {1'b0, ppr}) ? '0 : pos_reg + 1'b1;
        end
        else
        begin
            pos_next = (pos_reg == '0) ? ppr - 1'b1
                     : ((pos_reg - 1'b1) >= ppr ? '0 : pos_reg - 1'b1);
        end
    end

    // divider operands
    always_comb
    begin
        if (item.op == qpse_pkg::OP_TICK)
        begin
            div_num = qpse_pkg::DIVD_BITS'(qpse_pkg::US_PER_SECOND) * {20'd0, cnt_reg};
            div_den = TB'(period);
        end
        else
        begin
            div_num = qpse_pkg::DIVD_BITS'(qpse_pkg::US_PER_SECOND);
            div_den = gap;
        end
    end

    qpse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        item_take  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            qpse_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.op)
                        qpse_pkg::OP_PULSE:
                            if (!fast_reg)
                            begin
                                div_start  = (gap != '0);
                                state_next = (gap != '0) ? qpse_pkg::ST_DIVIDE
                                                         : qpse_pkg::ST_FILTER;
                            end
                            else
                            begin
                                state_next = qpse_pkg::ST_EMIT;
                            end
                        qpse_pkg::OP_TICK:
                            if (fast_reg)
                            begin
                                div_start  = (cnt_reg != '0);
                                state_next = (cnt_reg != '0) ? qpse_pkg::ST_DIVIDE
                                                             : qpse_pkg::ST_FILTER;
                            end
                            else if (gap > timeout)
                            begin
                                state_next = qpse_pkg::ST_FILTER;
                            end
                            else
                            begin
                                state_next = qpse_pkg::ST_MODE;
                            end
                        default: state_next = qpse_pkg::ST_EMIT;
                    endcase
                end
            end
            qpse_pkg::ST_DIVIDE:
                if (div_done)
                begin
                    state_next = qpse_pkg::ST_FILTER;
                end
            qpse_pkg::ST_FILTER:
                state_next = tick_reg ? qpse_pkg::ST_MODE : qpse_pkg::ST_EMIT;
            qpse_pkg::ST_MODE:
                state_next = qpse_pkg::ST_EMIT;
            qpse_pkg::ST_EMIT:
                if (out_free)
                begin
                    item_take  = 1'b1;
                    state_next = qpse_pkg::ST_IDLE;
                end
            default: state_next = qpse_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= qpse_pkg::ST_IDLE;
            pos_reg      <= '0;
            dir_reg      <= qpse_pkg::DIR_NONE;
            speed_reg    <= '0;
            cnt_reg      <= '0;
            last_reg     <= '0;
            fast_reg     <= 1'b0;
            out_full_reg <= 1'b0;
            tick_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && out_full_reg)
            begin
                out_full_reg <= 1'b0;
            end
            case (state_reg)
                qpse_pkg::ST_IDLE:
                    if (item_valid)
                    begin
                        tick_reg <= (item.op == qpse_pkg::OP_TICK);
                        if (item.op == qpse_pkg::OP_PULSE)
                        begin
                            dir_reg  <= item.dir;
                            pos_reg  <= pos_next;
                            last_reg <= item.now;
                            if (fast_reg && cnt_reg != '1)
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            // zero gap saturates, one pulse always
                            raw_reg <= qpse_pkg::SPEED_MAX;
                        end
                        else if (item.op == qpse_pkg::OP_TICK)
                        begin
                            raw_reg <= '0;
                        end
                        else
                        begin
                            pos_reg <= '0;
                        end
                    end
                qpse_pkg::ST_DIVIDE:
                    if (div_done)
                    begin
                        raw_reg <= div_q;
                    end
                qpse_pkg::ST_FILTER:
                    speed_reg <= filt[SB+2:3];
                qpse_pkg::ST_MODE:
                begin
                    cnt_reg  <= '0;
                    fast_reg <= (speed_reg > thresh);
                end
                qpse_pkg::ST_EMIT:
                    if (out_free)
                    begin
                        out_full_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == qpse_pkg::ST_EMIT && out_free)
        begin
            position_out  <= pos_reg;
            speed_out     <= speed_reg;
            fast_mode_out <= fast_reg;
            case (dir_reg)
                qpse_pkg::DIR_CCW: velocity_out <= $signed({1'b0, speed_reg});
                qpse_pkg::DIR_CW:  velocity_out <= -$signed({1'b0, speed_reg});
                default:           velocity_out <= '0;
            endcase
        end
    end

    a_take_emit: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> state_reg == qpse_pkg::ST_EMIT) else $error("take outside emit");
    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> out_full_reg) else $error("result not registered");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == qpse_pkg::ST_IDLE) else $error("divider restarted");

endmodule
